// File: rtl/core/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared types, sizes and index tables for the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int PairWidth = 48;
  localparam int AdjWidth  = 64;
  localparam int AccWidth  = 100;
  localparam int DivSteps  = 2 * FracBits + 1;

  typedef enum logic [4:0] {
    S_LOAD, S_PA_RA, S_PA_RB, S_PA_MUL, S_PA_WR,
    S_CF_RD, S_CF_ML, S_CF_MH, S_CF_AH, S_CF_WR,
    S_DT_RD, S_DT_ML, S_DT_MH, S_DT_AH, S_DT_FIN,
    S_DV_RD, S_DV_ST, S_DV_RUN, S_OUT
  } mi4_state_e;

  typedef struct packed {
    logic                       start;
    logic signed [AdjWidth-1:0] num;
    logic        [AccWidth-1:0] den;
    logic                       den_neg;
  } mi4_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DataWidth-1:0]  result;
  } mi4_div_rsp_t;

  // Element index of the transposed matrix, as a source address.
  function automatic logic [3:0] tsrc_addr(input logic [3:0] k);
    tsrc_addr = {k[1:0], k[3:2]};
  endfunction

  function automatic logic [3:0] pair_a(input logic [3:0] i);
    logic [47:0] row;
    row = 48'h98A8B8A9B9BA;
    pair_a = row[{i, 2'b00} +: 4];
  endfunction

  function automatic logic [3:0] pair_b(input logic [3:0] i);
    logic [47:0] row;
    row = 48'hCDCECFDEDFEF;
    pair_b = row[{i, 2'b00} +: 4];
  endfunction

  function automatic logic [3:0] cof_pair(input logic [2:0] e, input logic [2:0] t);
    logic [23:0] row;
    case (e)
      3'd0:    row = 24'h521430;
      3'd1:    row = 24'h870961;
      3'd2:    row = 24'hB63A72;
      3'd3:    row = 24'hA94B85;
      3'd4:    row = 24'h430521;
      3'd5:    row = 24'h961870;
      3'd6:    row = 24'hA72B63;
      default: row = 24'hB85A94;
    endcase
    cof_pair = row[{t, 2'b00} +: 4];
  endfunction

  function automatic logic [3:0] cof_elem(input logic [2:0] e, input logic [2:0] t);
    logic [23:0] row;
    case (e)
      3'd0:    row = 24'h765765;
      3'd1:    row = 24'h764764;
      3'd2:    row = 24'h754754;
      3'd3:    row = 24'h654654;
      3'd4:    row = 24'h321321;
      3'd5:    row = 24'h320320;
      3'd6:    row = 24'h310310;
      default: row = 24'h210210;
    endcase
    cof_elem = row[{t, 2'b00} +: 4];
  endfunction

endpackage

// File: rtl/core/mi4_ram.sv
// ----------------------------------------------------------------------------
// mi4_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module mi4_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/core/mi4_div.sv
// ----------------------------------------------------------------------------
// mi4_div
// Bit-serial restoring divider that scales one adjugate entry by the
// determinant and saturates the quotient to the element range.
// ----------------------------------------------------------------------------
module mi4_div
  import mi4_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mi4_div_req_t req_i,
  output mi4_div_rsp_t rsp_o
);

  logic                  busy_q, busy_d, done_q, done_d;
  logic [5:0]            cnt_q, cnt_d;
  logic [AccWidth:0]     r_q, r_d;
  logic [DivSteps-1:0]   q_q, q_d;
  logic                  nb_q, nb_d, ovf_q, ovf_d, neg_q, neg_d;
  logic [AdjWidth-1:0]   mag;
  logic [AccWidth:0]     r2, den_x;
  logic                  ge;

  assign mag   = req_i.num[AdjWidth-1] ? AdjWidth'(-req_i.num) : AdjWidth'(req_i.num);
  assign den_x = {1'b0, req_i.den};
  assign r2    = {r_q[AccWidth-1:0], (cnt_q == 6'd0) ? nb_q : 1'b0};
  assign ge    = r2 >= den_x;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    q_d    = q_q;
    nb_d   = nb_q;
    ovf_d  = ovf_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      q_d    = '0;
      r_d    = {{(AccWidth - AdjWidth + 2){1'b0}}, mag[AdjWidth-1:1]};
      nb_d   = mag[0];
      ovf_d  = {{(AccWidth - AdjWidth + 1){1'b0}}, mag[AdjWidth-1:1]} >= req_i.den;
      neg_d  = req_i.num[AdjWidth-1] ^ req_i.den_neg;
    end else if (busy_q) begin
      r_d = ge ? (r2 - den_x) : r2;
      q_d = {q_q[DivSteps-2:0], ge};
      if (cnt_q == 6'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    r_q   <= r_d;
    q_q   <= q_d;
    nb_q  <= nb_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    if (!neg_q) begin
      if (ovf_q || q_q[32] || q_q[31]) rsp_o.result = 32'h7fffffff;
      else                             rsp_o.result = q_q[31:0];
    end else begin
      if (ovf_q || q_q[32] || (q_q[31] && (q_q[30:0] != '0))) rsp_o.result = 32'h80000000;
      else                                                    rsp_o.result = -q_q[31:0];
    end
  end

endmodule

// File: rtl/core/matrix4x4_inverse.sv
// ----------------------------------------------------------------------------
// matrix4x4_inverse
// Inverse of a 4x4 signed Q16.16 matrix by cofactors and Cramer's rule.
// ----------------------------------------------------------------------------
// Sixteen elements are taken one per cycle in row-major order and held in a
// source RAM; after the last one the sequencer builds twice twelve pair
// products and sixteen adjugate entries through one shared registered
// multiplier, forms the determinant from the first column and divides every
// adjugate entry by it with a one-bit-per-cycle divider. The input is not
// ready again until all sixteen result beats have been taken. Each cofactor
// term passes through read, low multiply, high multiply and high add states,
// and each division waits until its result beat is taken before the next
// adjugate entry is read.
module matrix4x4_inverse
  import mi4_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DataWidth-1:0] element_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataWidth-1:0] element_out_o,
  output logic                        is_last_o,
  output logic                        singular_o
);

  mi4_state_e state_q, state_d;
  logic [3:0] load_q, idx_q;
  logic [2:0] term_q;
  logic       half_q;

  logic signed [DataWidth-1:0] a_q, e_q, hi_q;
  logic signed [64:0]          prod_q;
  logic signed [AccWidth-1:0]  acc_q;
  logic        [AccWidth-1:0]  dmag_q;
  logic                        dneg_q, sing_q;
  logic                        out_valid_q, out_last_q, out_sing_q;
  logic signed [DataWidth-1:0] out_elem_q;

  logic [3:0]                  src_raddr, pair_raddr, adj_raddr, adj_waddr, off;
  logic [DataWidth-1:0]        src_rdata;
  logic [PairWidth-1:0]        pair_rdata;
  logic [AdjWidth-1:0]         adj_rdata, adj_wdata;
  logic                        src_we, pair_we, adj_we;
  logic signed [32:0]          mul_a;
  logic signed [DataWidth-1:0] mul_b;
  logic signed [AccWidth-1:0]  lo_add, hi_add;
  logic                        sub;
  logic [83:0]                 sh;
  mi4_div_req_t                div_req;
  mi4_div_rsp_t                div_rsp;

  assign off    = {half_q, 3'b000};
  assign src_we = (state_q == S_LOAD) && in_valid_i;
  assign sh     = acc_q[AccWidth-1:16];
  assign lo_add = AccWidth'(prod_q);
  assign hi_add = {lo_add[AccWidth-33:0], 32'b0};
  assign sub    = (state_q inside {S_CF_MH, S_CF_AH}) && (term_q >= 3'd3);

  always_comb begin
    if ((&sh[83:63]) || !(|sh[83:63])) adj_wdata = sh[63:0];
    else if (sh[83])                   adj_wdata = 64'h8000000000000000;
    else                               adj_wdata = 64'h7fffffffffffffff;
  end

  mi4_ram #(.Width(DataWidth), .Depth(16)) u_src (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (load_q),
    .wdata_i (element_in_i),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  mi4_ram #(.Width(PairWidth), .Depth(12)) u_pair (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .waddr_i (idx_q),
    .wdata_i (prod_q[PairWidth+15:16]),
    .raddr_i (pair_raddr),
    .rdata_o (pair_rdata)
  );

  mi4_ram #(.Width(AdjWidth), .Depth(16)) u_adj (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  mi4_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:   if (in_valid_i && load_q == 4'd15) state_d = S_PA_RA;
      S_PA_RA:  state_d = S_PA_RB;
      S_PA_RB:  state_d = S_PA_MUL;
      S_PA_MUL: state_d = S_PA_WR;
      S_PA_WR:  state_d = (idx_q == 4'd11) ? S_CF_RD : S_PA_RA;
      S_CF_RD:  state_d = S_CF_ML;
      S_CF_ML:  state_d = S_CF_MH;
      S_CF_MH:  state_d = S_CF_AH;
      S_CF_AH:  state_d = (term_q == 3'd5) ? S_CF_WR : S_CF_RD;
      S_CF_WR: begin
        if (idx_q[2:0] != 3'd7) state_d = S_CF_RD;
        else if (!half_q)       state_d = S_PA_RA;
        else                    state_d = S_DT_RD;
      end
      S_DT_RD:  state_d = S_DT_ML;
      S_DT_ML:  state_d = S_DT_MH;
      S_DT_MH:  state_d = S_DT_AH;
      S_DT_AH:  state_d = (idx_q == 4'd3) ? S_DT_FIN : S_DT_RD;
      S_DT_FIN: state_d = S_DV_RD;
      S_DV_RD:  state_d = S_DV_ST;
      S_DV_ST:  state_d = S_DV_RUN;
      S_DV_RUN: if (div_rsp.done) state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) state_d = (idx_q == 4'd15) ? S_LOAD : S_DV_RD;
      end
      default:  state_d = S_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_LOAD);
    src_raddr   = '0;
    pair_raddr  = cof_pair(idx_q[2:0], term_q);
    adj_raddr   = idx_q;
    adj_waddr   = {half_q, idx_q[2:0]};
    pair_we     = (state_q == S_PA_WR);
    adj_we      = (state_q == S_CF_WR);
    mul_a       = {a_q[DataWidth-1], a_q};
    mul_b       = src_rdata;
    div_req.start   = (state_q == S_DV_ST);
    div_req.num     = adj_rdata;
    div_req.den     = dmag_q;
    div_req.den_neg = dneg_q;
    case (state_q)
      S_PA_RA:  src_raddr = tsrc_addr(pair_a(idx_q) - off);
      S_PA_RB:  src_raddr = tsrc_addr(pair_b(idx_q) - off);
      S_CF_RD:  src_raddr = tsrc_addr(cof_elem(idx_q[2:0], term_q) + off);
      S_DT_RD:  src_raddr = tsrc_addr(idx_q);
      S_CF_ML:  mul_a = {1'b0, pair_rdata[31:0]};
      S_DT_ML:  mul_a = {1'b0, adj_rdata[31:0]};
      S_CF_MH, S_DT_MH: begin
        mul_a = {hi_q[DataWidth-1], hi_q};
        mul_b = e_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_q      <= '0;
      idx_q       <= '0;
      term_q      <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: if (in_valid_i) begin
          load_q <= load_q + 4'd1;
          idx_q  <= '0;
          half_q <= 1'b0;
        end
        S_PA_WR: begin
          idx_q  <= (idx_q == 4'd11) ? 4'd0 : idx_q + 4'd1;
          term_q <= '0;
        end
        S_CF_AH: if (term_q != 3'd5) term_q <= term_q + 3'd1;
        S_CF_WR: begin
          term_q <= '0;
          if (idx_q[2:0] == 3'd7) begin
            idx_q  <= '0;
            half_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 4'd1;
          end
        end
        S_DT_AH:  idx_q <= (idx_q == 4'd3) ? 4'd0 : idx_q + 4'd1;
        S_DV_RUN: if (div_rsp.done) out_valid_q <= 1'b1;
        S_OUT: if (out_ready_i) begin
          out_valid_q <= 1'b0;
          idx_q       <= idx_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_PA_RB: a_q <= src_rdata;
      S_PA_WR: acc_q <= '0;
      S_CF_ML: begin
        hi_q <= DataWidth'(signed'(pair_rdata[PairWidth-1:32]));
        e_q  <= src_rdata;
      end
      S_DT_ML: begin
        hi_q <= adj_rdata[AdjWidth-1:32];
        e_q  <= src_rdata;
      end
      S_CF_MH, S_DT_MH: acc_q <= sub ? acc_q - lo_add : acc_q + lo_add;
      S_CF_AH, S_DT_AH: acc_q <= sub ? acc_q - hi_add : acc_q + hi_add;
      S_CF_WR: acc_q <= '0;
      S_DT_FIN: begin
        dmag_q <= acc_q[AccWidth-1] ? AccWidth'(-acc_q) : AccWidth'(acc_q);
        dneg_q <= acc_q[AccWidth-1];
        sing_q <= (acc_q == '0);
      end
      S_DV_RUN: if (div_rsp.done) begin
        out_elem_q <= sing_q ? '0 : div_rsp.result;
        out_last_q <= (idx_q == 4'd15);
        out_sing_q <= sing_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign element_out_o = out_elem_q;
  assign is_last_o     = out_last_q;
  assign singular_o    = out_sing_q;

endmodule
